FILE: hdl/bblur_pkg.sv
package bblur_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // counters
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // divide by neighbor count: multiply by ceil(2^RECIP_SH / n)
    localparam int N_W      = 4;
    localparam int SUM_W    = $clog2(9 * (2 ** CH_W - 1) + 1);
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;

    // queues
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [COL_W-1:0] addr;
        pix_t             pix;
        logic             shift;
        logic             emit;
        logic             use_old;
        logic             fend;
        logic             col0;
        logic             col1;
        logic             top;
        logic             bot;
        logic [N_W-1:0]   n;
    } cmd_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fend;
    } res_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            N_W'(1):  m = RECIP_W'(65536);
            N_W'(2):  m = RECIP_W'(32768);
            N_W'(3):  m = RECIP_W'(21846);
            N_W'(4):  m = RECIP_W'(16384);
            N_W'(5):  m = RECIP_W'(13108);
            N_W'(6):  m = RECIP_W'(10923);
            N_W'(7):  m = RECIP_W'(9363);
            N_W'(8):  m = RECIP_W'(8192);
            N_W'(9):  m = RECIP_W'(7282);
            default:  m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/box_blur_3x3_rgb_core.sv
// 3x3 box blur over an RGB frame streamed in raster order.
// Input: a queue write port (push/full). Write width*height pixels, then
// width+1 flush requests; position alone decides what is pixel and what is
// padding. Output: a queue read port (empty/pop); each request carries the
// truncated mean of the pixel's in-frame neighbors, frame_end on the last one.
// Config: cfg_valid/cfg_ready (always ready), cfg_index 0 = width, 1 = height.
// A write to either restarts the frame; write only while the block is idle.
// Throughput: one request per cycle in and out unless stalled. The front
// classifies each request into a 4-deep command queue; the back reads the
// two-row line store (single RAM, one read and one write per cycle),
// shifts the window, sums, and divides by reciprocal multiply into a
// 4-deep result queue. Results pass through stages B, C and D, and they
// trail the inputs by width+1 requests.
// Reset: width 640, height 480, counters and queues cleared; the line store
// is not cleared. When the reader stalls, the result queue fills, the back
// pipeline holds, the command queue fills and full rises.
module box_blur_3x3_rgb_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [bblur_pkg::CH_W-1:0]      in_blue,
    input  logic [bblur_pkg::CH_W-1:0]      in_green,
    input  logic [bblur_pkg::CH_W-1:0]      in_red,
    input  logic                            flush,
    output logic                            empty,
    input  logic                            pop,
    output logic [bblur_pkg::CH_W-1:0]      out_blue,
    output logic [bblur_pkg::CH_W-1:0]      out_green,
    output logic [bblur_pkg::CH_W-1:0]      out_red,
    output logic                            frame_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bblur_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0]     cfg_data
);

    bblur_pkg::cmd_t cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    bblur_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_blue   (in_blue),
        .in_green  (in_green),
        .in_red    (in_red),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    bblur_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .frame_end (frame_end)
    );

endmodule

FILE: hdl/bblur_ram.sv
module bblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bblur_front.sv
module bblur_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [bblur_pkg::CH_W-1:0]        in_blue,
    input  logic [bblur_pkg::CH_W-1:0]        in_green,
    input  logic [bblur_pkg::CH_W-1:0]        in_red,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0]       cfg_data,
    output bblur_pkg::cmd_t                   cmd,
    output logic                              cmd_valid,
    input  logic                              cmd_pop
);

    localparam int COL_W = bblur_pkg::COL_W;
    localparam int EW_W  = bblur_pkg::EW_W;
    localparam int EH_W  = bblur_pkg::EH_W;
    localparam int ROW_W = bblur_pkg::ROW_W;
    localparam int N_W   = bblur_pkg::N_W;

    logic [bblur_pkg::CFG_W-1:0] width_reg, width_next;
    logic [bblur_pkg::CFG_W-1:0] height_reg, height_next;
    logic                        cfg_hit;
    logic [EW_W-1:0]             eff_w;
    logic [EH_W-1:0]             eff_h;
    logic [ROW_W-1:0]            rh;
    logic [ROW_W-1:0]            h_plus1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [EW_W-1:0]  col_inc;
    logic             row_last;
    logic             accept;
    logic             at_c0;
    logic             in_frame;
    logic             start;
    logic             second;
    logic             fend;
    logic [N_W-1:0]   ncols;
    logic [N_W-1:0]   nrows;
    bblur_pkg::cmd_t  cmd_in;

    bblur_pkg::cmd_t                   cq_mem_reg [bblur_pkg::CQ_DEPTH];
    logic [bblur_pkg::CQ_PTR_W-1:0]    cq_wr_reg, cq_wr_next;
    logic [bblur_pkg::CQ_PTR_W-1:0]    cq_rd_reg, cq_rd_next;
    logic [bblur_pkg::CQ_CNT_W-1:0]    cq_cnt_reg, cq_cnt_next;
    logic                              cq_pop;

    // config
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bblur_pkg::REG_WIDTH:
                begin
                    width_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                bblur_pkg::REG_HEIGHT:
                begin
                    height_next = cfg_data;
                    cfg_hit     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (int'(width_reg) > bblur_pkg::MAX_WIDTH)
        begin
            eff_w = EW_W'(bblur_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            eff_h = EH_W'(1);
        end
        else if (int'(height_reg) > bblur_pkg::MAX_HEIGHT)
        begin
            eff_h = EH_W'(bblur_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = EH_W'(height_reg);
        end
    end

    // classify
    assign rh       = ROW_W'(eff_h);
    assign h_plus1  = rh + ROW_W'(1);
    assign accept   = push && !full;
    assign at_c0    = (col_reg == '0);
    assign in_frame = (row_reg < rh);
    assign start    = at_c0 && (row_reg >= ROW_W'(2));
    assign fend     = start && (row_reg == h_plus1);
    assign second   = !at_c0 && (row_reg != '0);
    assign col_inc  = EW_W'(col_reg) + EW_W'(1);
    assign row_last = (col_inc >= eff_w);

    always_comb
    begin
        cmd_in.addr    = col_reg;
        cmd_in.pix     = in_frame ? {in_red, in_green, in_blue} : '0;
        cmd_in.shift   = !fend;
        cmd_in.emit    = start || second;
        cmd_in.use_old = start;
        cmd_in.fend    = fend;
        cmd_in.col0    = start ? 1'b0 : (col_reg >= COL_W'(2));
        cmd_in.col1    = start ? (eff_w >= EW_W'(2)) : 1'b1;
        cmd_in.top     = start ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
        cmd_in.bot     = start ? (row_reg <= rh) : in_frame;
        ncols          = N_W'(1) + N_W'(cmd_in.col0) + N_W'(cmd_in.col1);
        nrows          = N_W'(1) + N_W'(cmd_in.top) + N_W'(cmd_in.bot);
        cmd_in.n       = N_W'(ncols * nrows);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (fend)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // command queue
    assign full      = (cq_cnt_reg == bblur_pkg::CQ_CNT_W'(bblur_pkg::CQ_DEPTH));
    assign cmd_valid = (cq_cnt_reg != '0);
    assign cmd       = cq_mem_reg[cq_rd_reg];
    assign cq_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        cq_wr_next  = accept ? cq_wr_reg + bblur_pkg::CQ_PTR_W'(1) : cq_wr_reg;
        cq_rd_next  = cq_pop ? cq_rd_reg + bblur_pkg::CQ_PTR_W'(1) : cq_rd_reg;
        cq_cnt_next = cq_cnt_reg + bblur_pkg::CQ_CNT_W'(accept)
                      - bblur_pkg::CQ_CNT_W'(cq_pop);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cq_mem_reg[cq_wr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bblur_pkg::WIDTH_RESET;
            height_reg <= bblur_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            cq_wr_reg  <= '0;
            cq_rd_reg  <= '0;
            cq_cnt_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cq_wr_reg  <= cq_wr_next;
            cq_rd_reg  <= cq_rd_next;
            cq_cnt_reg <= cq_cnt_next;
        end
    end

endmodule

FILE: hdl/bblur_back.sv
module bblur_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bblur_pkg::cmd_t            cmd,
    input  logic                       cmd_valid,
    output logic                       cmd_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [bblur_pkg::CH_W-1:0] out_blue,
    output logic [bblur_pkg::CH_W-1:0] out_green,
    output logic [bblur_pkg::CH_W-1:0] out_red,
    output logic                       frame_end
);

    localparam int CH_W     = bblur_pkg::CH_W;
    localparam int PIX_W    = bblur_pkg::PIX_W;
    localparam int COL_W    = bblur_pkg::COL_W;
    localparam int SUM_W    = bblur_pkg::SUM_W;
    localparam int PROD_W   = bblur_pkg::PROD_W;
    localparam int RECIP_SH = bblur_pkg::RECIP_SH;

    logic en;

    // stage B: row store data back, window shift
    logic                  b_valid_reg;
    bblur_pkg::cmd_t       b_cmd_reg;
    logic [2*PIX_W-1:0]    ram_rdata;
    logic [2*PIX_W-1:0]    row_data;
    logic                  ram_we;
    logic                  fwd_valid_reg;
    logic [COL_W-1:0]      fwd_addr_reg;
    logic [2*PIX_W-1:0]    fwd_data_reg;
    bblur_pkg::pix_t       above1;
    bblur_pkg::pix_t       above2;
    bblur_pkg::pix_t       win_reg   [3][3];
    bblur_pkg::pix_t       win_shift [3][3];
    bblur_pkg::pix_t       snap      [3][3];

    // stage C: masked sums
    logic                  c_valid_reg;
    bblur_pkg::pix_t       c_snap_reg [3][3];
    logic [2:0]            c_row_en_reg;
    logic [2:0]            c_col_en_reg;
    logic [bblur_pkg::N_W-1:0] c_n_reg;
    logic                  c_fend_reg;
    logic [SUM_W-1:0]      sum_b, sum_g, sum_r;

    // stage D: reciprocal multiply
    logic                  d_valid_reg;
    logic [SUM_W-1:0]      d_sum_b_reg, d_sum_g_reg, d_sum_r_reg;
    logic [bblur_pkg::RECIP_W-1:0] d_recip_reg;
    logic                  d_fend_reg;
    logic [PROD_W-1:0]     prod_b, prod_g, prod_r;
    bblur_pkg::res_t       res_in;

    // result queue
    bblur_pkg::res_t                 oq_mem_reg [bblur_pkg::OQ_DEPTH];
    logic [bblur_pkg::OQ_PTR_W-1:0]  oq_wr_reg, oq_wr_next;
    logic [bblur_pkg::OQ_PTR_W-1:0]  oq_rd_reg, oq_rd_next;
    logic [bblur_pkg::OQ_CNT_W-1:0]  oq_cnt_reg, oq_cnt_next;
    logic                            oq_full;
    logic                            oq_push;
    logic                            oq_pop;
    bblur_pkg::res_t                 res_out;

    assign oq_full = (oq_cnt_reg == bblur_pkg::OQ_CNT_W'(bblur_pkg::OQ_DEPTH));
    assign en      = !(d_valid_reg && oq_full);
    assign cmd_pop = en && cmd_valid;

    // entry holds {row above, row two above}
    assign ram_we = en && b_valid_reg && b_cmd_reg.shift;

    bblur_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (bblur_pkg::MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_cmd_reg.addr),
        .wdata ({b_cmd_reg.pix, above1}),
        .re    (cmd_pop),
        .raddr (cmd.addr),
        .rdata (ram_rdata)
    );

    // write in the same cycle as the read of this address
    assign row_data = (fwd_valid_reg && (fwd_addr_reg == b_cmd_reg.addr)) ?
                      fwd_data_reg : ram_rdata;
    assign above2   = row_data[PIX_W-1:0];
    assign above1   = row_data[2*PIX_W-1:PIX_W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_shift[i][0] = win_reg[i][1];
            win_shift[i][1] = win_reg[i][2];
        end
        win_shift[0][2] = above2;
        win_shift[1][2] = above1;
        win_shift[2][2] = b_cmd_reg.pix;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                snap[i][j] = b_cmd_reg.use_old ? win_reg[i][j] : win_shift[i][j];
            end
        end
    end

    always_comb
    begin
        sum_b = '0;
        sum_g = '0;
        sum_r = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (c_row_en_reg[i] && c_col_en_reg[j])
                begin
                    sum_b = sum_b + SUM_W'(c_snap_reg[i][j][CH_W-1:0]);
                    sum_g = sum_g + SUM_W'(c_snap_reg[i][j][2*CH_W-1:CH_W]);
                    sum_r = sum_r + SUM_W'(c_snap_reg[i][j][3*CH_W-1:2*CH_W]);
                end
            end
        end
    end

    always_comb
    begin
        prod_b       = PROD_W'(d_sum_b_reg) * PROD_W'(d_recip_reg);
        prod_g       = PROD_W'(d_sum_g_reg) * PROD_W'(d_recip_reg);
        prod_r       = PROD_W'(d_sum_r_reg) * PROD_W'(d_recip_reg);
        res_in.blue  = prod_b[RECIP_SH+CH_W-1:RECIP_SH];
        res_in.green = prod_g[RECIP_SH+CH_W-1:RECIP_SH];
        res_in.red   = prod_r[RECIP_SH+CH_W-1:RECIP_SH];
        res_in.fend  = d_fend_reg;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cmd_pop)
            begin
                b_cmd_reg <= cmd;
            end
            fwd_addr_reg <= b_cmd_reg.addr;
            fwd_data_reg <= {b_cmd_reg.pix, above1};
            c_snap_reg   <= snap;
            c_row_en_reg <= {b_cmd_reg.bot, 1'b1, b_cmd_reg.top};
            c_col_en_reg <= {1'b1, b_cmd_reg.col1, b_cmd_reg.col0};
            c_n_reg      <= b_cmd_reg.n;
            c_fend_reg   <= b_cmd_reg.fend;
            d_sum_b_reg  <= sum_b;
            d_sum_g_reg  <= sum_g;
            d_sum_r_reg  <= sum_r;
            d_recip_reg  <= bblur_pkg::recip(c_n_reg);
            d_fend_reg   <= c_fend_reg;
        end
        if (oq_push)
        begin
            oq_mem_reg[oq_wr_reg] <= res_in;
        end
    end

    // control and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            win_reg       <= '{default: '0};
        end
        else if (en)
        begin
            b_valid_reg   <= cmd_pop;
            fwd_valid_reg <= ram_we;
            c_valid_reg   <= b_valid_reg && b_cmd_reg.emit;
            d_valid_reg   <= c_valid_reg;
            if (ram_we)
            begin
                win_reg <= win_shift;
            end
        end
    end

    // result queue
    assign oq_push = en && d_valid_reg;
    assign oq_pop  = pop && !empty;
    assign empty   = (oq_cnt_reg == '0);
    assign res_out = oq_mem_reg[oq_rd_reg];

    assign out_blue  = res_out.blue;
    assign out_green = res_out.green;
    assign out_red   = res_out.red;
    assign frame_end = res_out.fend;

    always_comb
    begin
        oq_wr_next  = oq_push ? oq_wr_reg + bblur_pkg::OQ_PTR_W'(1) : oq_wr_reg;
        oq_rd_next  = oq_pop ? oq_rd_reg + bblur_pkg::OQ_PTR_W'(1) : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + bblur_pkg::OQ_CNT_W'(oq_push)
                      - bblur_pkg::OQ_CNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

FILE: test/box_blur_3x3_rgb_core_test.sv
`timescale 1ns / 100ps

module box_blur_3x3_rgb_core_test;

    localparam logic [bblur_pkg::CFG_IDX_W-1:0] REG_SPARE_A = bblur_pkg::CFG_IDX_W'(2);
    localparam logic [bblur_pkg::CFG_IDX_W-1:0] REG_SPARE_B = bblur_pkg::CFG_IDX_W'(3);
    localparam int GAP_NONE  = 0;
    localparam int GAP_SHORT = 1;
    localparam int GAP_MIXED = 2;

    class blur_tracker;
        logic [bblur_pkg::CFG_W-1:0] width_reg;
        logic [bblur_pkg::CFG_W-1:0] height_reg;
        bblur_pkg::pix_t             line_rows [2*bblur_pkg::MAX_WIDTH];
        bblur_pkg::pix_t             nbhd [3][3];
        int unsigned                 col;
        int unsigned                 row;
        bblur_pkg::res_t             pending [$];
        int                          mismatches;
        int                          results_seen;

        function new();
            width_reg    = bblur_pkg::WIDTH_RESET;
            height_reg   = bblur_pkg::HEIGHT_RESET;
            col          = 0;
            row          = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (line_rows[i]) line_rows[i] = '0;
            foreach (nbhd[i, j]) nbhd[i][j] = '0;
        endfunction

        function int unsigned width_now();
            if (width_reg == 0) return 1;
            if (width_reg > bblur_pkg::MAX_WIDTH) return bblur_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned height_now();
            if (height_reg == 0) return 1;
            if (height_reg > bblur_pkg::MAX_HEIGHT) return bblur_pkg::MAX_HEIGHT;
            return height_reg;
        endfunction

        function void set_reg(logic [bblur_pkg::CFG_IDX_W-1:0] idx,
                              logic [bblur_pkg::CFG_W-1:0] data);
            if (idx == bblur_pkg::REG_WIDTH) width_reg = data;
            else if (idx == bblur_pkg::REG_HEIGHT) height_reg = data;
            else return;
            col = 0;
            row = 0;
        endfunction

        // truncated mean over window columns c0..c1, middle row always in
        function bblur_pkg::res_t mean_of(int c0, int c1, bit top, bit bot);
            int unsigned     sb;
            int unsigned     sg;
            int unsigned     sr;
            int unsigned     n;
            int              r0;
            int              r1;
            bblur_pkg::res_t m;
            sb = 0;
            sg = 0;
            sr = 0;
            n  = 0;
            r0 = top ? 0 : 1;
            r1 = bot ? 2 : 1;
            for (int i = r0; i <= r1; i++)
            begin
                for (int j = c0; j <= c1; j++)
                begin
                    sb += nbhd[i][j][7:0];
                    sg += nbhd[i][j][15:8];
                    sr += nbhd[i][j][23:16];
                    n++;
                end
            end
            m.blue  = bblur_pkg::CH_W'(sb / n);
            m.green = bblur_pkg::CH_W'(sg / n);
            m.red   = bblur_pkg::CH_W'(sr / n);
            m.fend  = 1'b0;
            return m;
        endfunction

        function void take_pixel(logic [bblur_pkg::CH_W-1:0] b,
                                 logic [bblur_pkg::CH_W-1:0] g,
                                 logic [bblur_pkg::CH_W-1:0] r);
            int unsigned     w;
            int unsigned     h;
            int unsigned     c;
            int unsigned     rw;
            bblur_pkg::pix_t px;
            bblur_pkg::pix_t up2;
            bblur_pkg::pix_t up1;
            bblur_pkg::res_t want;
            w  = width_now();
            h  = height_now();
            c  = col;
            rw = row;
            px = (rw < h) ? {r, g, b} : '0;
            // row start: last pixel of the row two above leaves first
            if (c == 0 && rw >= 2)
            begin
                want = mean_of(w >= 2 ? 1 : 2, 2, rw >= 3, (rw - 1) < h);
                if (rw == h + 1)
                begin
                    want.fend = 1'b1;
                    pending.push_back(want);
                    col = 0;
                    row = 0;
                    return;
                end
                pending.push_back(want);
            end
            up2 = line_rows[c];
            up1 = line_rows[bblur_pkg::MAX_WIDTH + c];
            for (int i = 0; i < 3; i++)
            begin
                nbhd[i][0] = nbhd[i][1];
                nbhd[i][1] = nbhd[i][2];
            end
            nbhd[0][2] = up2;
            nbhd[1][2] = up1;
            nbhd[2][2] = px;
            line_rows[c]                        = up1;
            line_rows[bblur_pkg::MAX_WIDTH + c] = px;
            if (c >= 1 && rw >= 1)
                pending.push_back(mean_of(c >= 2 ? 0 : 1, 2, rw >= 2, rw < h));
            c++;
            if (c >= w)
            begin
                c = 0;
                rw++;
            end
            col = c;
            row = rw;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("%t mismatch: %s", $realtime, msg);
        endtask

        task match_output(logic [bblur_pkg::CH_W-1:0] b, logic [bblur_pkg::CH_W-1:0] g,
                          logic [bblur_pkg::CH_W-1:0] r, logic fe);
            bblur_pkg::res_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("result %0d unexpected: r=%0d g=%0d b=%0d end=%0b",
                                 results_seen, r, g, b, fe));
                return;
            end
            want = pending.pop_front();
            if (r !== want.red)
                report($sformatf("result %0d red %0d, want %0d", results_seen, r, want.red));
            if (g !== want.green)
                report($sformatf("result %0d green %0d, want %0d", results_seen, g,
                                 want.green));
            if (b !== want.blue)
                report($sformatf("result %0d blue %0d, want %0d", results_seen, b, want.blue));
            if (fe !== want.fend)
                report($sformatf("result %0d frame_end %0b, want %0b", results_seen, fe,
                                 want.fend));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              push;
    logic                              full;
    logic [bblur_pkg::CH_W-1:0]        in_blue;
    logic [bblur_pkg::CH_W-1:0]        in_green;
    logic [bblur_pkg::CH_W-1:0]        in_red;
    logic                              flush;
    logic                              empty;
    logic                              pop;
    logic [bblur_pkg::CH_W-1:0]        out_blue;
    logic [bblur_pkg::CH_W-1:0]        out_green;
    logic [bblur_pkg::CH_W-1:0]        out_red;
    logic                              frame_end;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [bblur_pkg::CFG_W-1:0]       cfg_data;

    blur_tracker blur;
    int          in_mode;
    int          out_mode;
    int          pixels_sent;

    box_blur_3x3_rgb_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_blue   (in_blue),
        .in_green  (in_green),
        .in_red    (in_red),
        .flush     (flush),
        .empty     (empty),
        .pop       (pop),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap(int mode);
        int p;
        if (mode == GAP_NONE) return 0;
        p = $urandom_range(0, 99);
        if (mode == GAP_SHORT) return (p < 70) ? 0 : $urandom_range(1, 3);
        if (p < 60) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [bblur_pkg::CH_W-1:0] chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return bblur_pkg::CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [bblur_pkg::CFG_W-1:0] pick_dim();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return '0;
        if (p == 1) return bblur_pkg::CFG_W'($urandom_range(7, 24));
        return bblur_pkg::CFG_W'($urandom_range(1, 6));
    endfunction

    task automatic send_px(input logic [bblur_pkg::CH_W-1:0] b,
                           input logic [bblur_pkg::CH_W-1:0] g,
                           input logic [bblur_pkg::CH_W-1:0] r, input logic fl);
        int gap;
        gap = pick_gap(in_mode);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        in_blue  <= b;
        in_green <= g;
        in_red   <= r;
        flush    <= fl;
        @(posedge clk);
        while (full) @(posedge clk);
        blur.take_pixel(b, g, r);
        pixels_sent++;
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h, input bit cut);
        int unsigned total;
        int unsigned stop;
        logic        fl;
        total = w * h + w + 1;
        stop  = total;
        if (cut && total > 1) stop = $urandom_range(1, total - 1);
        for (int unsigned k = 0; k < stop; k++)
        begin
            if (k < w * h) fl = ($urandom_range(0, 9) == 0);
            else fl = ($urandom_range(0, 9) != 0);
            send_px(chan(), chan(), chan(), fl);
        end
    endtask

    task automatic write_reg(input logic [bblur_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bblur_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        blur.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // padding requests may still be in flight after the last result
    task automatic settle();
        push <= 1'b0;
        while (blur.pending.size() > 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                blur.match_output(out_blue, out_green, out_red, frame_end);
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                stall = pick_gap(out_mode);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("box_blur_3x3_rgb_core_test: errors");
        $finish;
    end

    initial
    begin
        int  start;
        int  frames;
        bit  cut;
        blur        = new();
        pixels_sent = 0;
        in_mode     = GAP_SHORT;
        out_mode    = GAP_SHORT;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        in_blue   <= '0;
        in_green  <= '0;
        in_red    <= '0;
        flush     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= bblur_pkg::REG_WIDTH;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: start of the first row of a 640-wide frame
        repeat (40) send_px(chan(), chan(), chan(), 1'($urandom_range(0, 1)));
        settle();

        // 3x2 with extremes; flush bit ignored on a pixel, missing on a pad
        write_reg(bblur_pkg::REG_WIDTH, bblur_pkg::CFG_W'(3));
        write_reg(bblur_pkg::REG_HEIGHT, bblur_pkg::CFG_W'(2));
        send_px(8'd255, 8'd255, 8'd255, 1'b0);
        send_px(8'd0, 8'd0, 8'd0, 1'b0);
        send_px(8'd255, 8'd0, 8'd255, 1'b0);
        send_px(8'd0, 8'd255, 8'd0, 1'b0);
        send_px(8'd255, 8'd255, 8'd255, 1'b1);
        send_px(8'd1, 8'd2, 8'd3, 1'b0);
        send_px(8'd9, 8'd9, 8'd9, 1'b1);
        send_px(8'd9, 8'd9, 8'd9, 1'b1);
        send_px(8'd9, 8'd9, 8'd9, 1'b0);
        send_px(8'd9, 8'd9, 8'd9, 1'b1);
        settle();

        // zero sizes act as 1x1; two frames back to back
        write_reg(bblur_pkg::REG_WIDTH, '0);
        write_reg(bblur_pkg::REG_HEIGHT, '0);
        send_px(8'd255, 8'd255, 8'd255, 1'b0);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        send_px(8'd77, 8'd128, 8'd0, 1'b0);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        settle();

        // unused indexes change nothing
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, bblur_pkg::CFG_W'(13'h1555));
        write_reg(bblur_pkg::REG_WIDTH, bblur_pkg::CFG_W'(2));
        write_reg(bblur_pkg::REG_HEIGHT, bblur_pkg::CFG_W'(1));
        send_px(8'd255, 8'd0, 8'd128, 1'b0);
        send_px(8'd0, 8'd255, 8'd127, 1'b0);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        send_px(8'd0, 8'd0, 8'd0, 1'b1);
        settle();

        // largest sizes, exact and saturated: first requests of each frame
        write_reg(bblur_pkg::REG_WIDTH, bblur_pkg::CFG_W'(bblur_pkg::MAX_WIDTH));
        repeat (12) send_px(chan(), chan(), chan(), 1'b0);
        settle();
        write_reg(bblur_pkg::REG_WIDTH, '1);
        repeat (12) send_px(chan(), chan(), chan(), 1'b0);
        settle();
        write_reg(bblur_pkg::REG_WIDTH, bblur_pkg::CFG_W'(1));
        write_reg(bblur_pkg::REG_HEIGHT, bblur_pkg::CFG_W'(bblur_pkg::MAX_HEIGHT));
        repeat (24) send_px(chan(), chan(), chan(), 1'b0);
        settle();
        write_reg(bblur_pkg::REG_HEIGHT, '1);
        repeat (24) send_px(chan(), chan(), chan(), 1'b0);
        settle();

        // random geometry, mostly whole frames, some cut short
        start = pixels_sent;
        cut   = 1'b1;
        while (pixels_sent - start < 300)
        begin
            in_mode  = $urandom_range(GAP_NONE, GAP_MIXED);
            out_mode = $urandom_range(GAP_NONE, GAP_MIXED);
            if (cut || $urandom_range(0, 3) != 0)
                write_reg(bblur_pkg::REG_WIDTH, pick_dim());
            if (cut || $urandom_range(0, 3) != 0)
                write_reg(bblur_pkg::REG_HEIGHT, pick_dim());
            frames = $urandom_range(1, 3);
            cut    = 1'b0;
            for (int f = 0; f < frames && !cut; f++)
            begin
                cut = ($urandom_range(0, 7) == 0);
                send_frame(blur.width_now(), blur.height_now(), cut);
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (blur.mismatches == 0 && blur.pending.size() == 0)
            $display("box_blur_3x3_rgb_core_test: clean");
        else
            $display("box_blur_3x3_rgb_core_test: errors");
        $finish;
    end

endmodule
